### rtl/integer_to_roman_numeral_encoder_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef INTEGER_TO_ROMAN_NUMERAL_ENCODER_CORE_MACROS_SVH
`define INTEGER_TO_ROMAN_NUMERAL_ENCODER_CORE_MACROS_SVH

// Plain property, sampled on the clock and muted during reset.
`define RNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication built on the plain form.
`define RNE_ASSERT_IMP(lbl, ante, cons, msg) \
  `RNE_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### rtl/rne_pkg.sv
package rne_pkg;

  localparam int unsigned ValueW      = 32;
  localparam int unsigned LetterW     = 8;
  localparam int unsigned WeightW     = 13;
  localparam int unsigned RemW        = WeightW + 1;
  localparam int unsigned NumStages   = 7;
  localparam int unsigned StageW      = 3;
  localparam int unsigned MaxResults  = 12;
  localparam int unsigned CountW      = $clog2(MaxResults + 1);
  localparam int unsigned DefMaxValue = 3999;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SPECIAL,
    OP_GREEDY,
    OP_SKIP,
    OP_SUB_FIRST,
    OP_SUB_NEXT,
    OP_SUB_CLOSE
  } rne_op_e;

  typedef struct packed {
    rne_op_e op;
    logic    last;
  } rne_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_empty;
    logic in_big;
    logic can_greedy;
    logic can_sub;
    logic greedy_zero;
    logic rem_neg;
    logic rem_zero;
  } rne_stat_t;

  function automatic logic [WeightW-1:0] numeral_weight(input logic [StageW-1:0] s);
    logic [WeightW-1:0] w;
    case (s)
      3'd0:    w = WeightW'(1);
      3'd1:    w = WeightW'(5);
      3'd2:    w = WeightW'(10);
      3'd3:    w = WeightW'(50);
      3'd4:    w = WeightW'(100);
      3'd5:    w = WeightW'(500);
      3'd6:    w = WeightW'(1000);
      default: w = WeightW'(1);
    endcase
    return w;
  endfunction

  function automatic logic [LetterW-1:0] numeral_letter(input logic [StageW-1:0] s);
    logic [LetterW-1:0] c;
    case (s)
      3'd0:    c = "I";
      3'd1:    c = "V";
      3'd2:    c = "X";
      3'd3:    c = "L";
      3'd4:    c = "C";
      3'd5:    c = "D";
      3'd6:    c = "M";
      default: c = "I";
    endcase
    return c;
  endfunction

  function automatic logic [StageW-1:0] numeral_sub(input logic [StageW-1:0] s);
    logic [StageW-1:0] b;
    case (s)
      3'd3, 3'd4: b = StageW'(2);
      3'd5, 3'd6: b = StageW'(4);
      default:    b = StageW'(0);
    endcase
    return b;
  endfunction

endpackage

### rtl/rne_datapath.sv
module rne_datapath import rne_pkg::*; #(
  parameter int unsigned MaxValue = DefMaxValue
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ValueW-1:0]   value_i,
  input  rne_cmd_t            cmd_i,
  output rne_stat_t           stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LetterW-1:0]  letter_o,
  output logic                empty_res_o,
  output logic                too_large_o,
  output logic                last_o
);

  logic signed [RemW-1:0]  rem_q, rem_d;
  logic [StageW-1:0]       stage_q, stage_d;
  logic                    out_valid_q, out_valid_d;
  logic [LetterW-1:0]      letter_q, letter_d;
  logic                    empty_q, empty_d;
  logic                    big_q, big_d;
  logic                    last_q, last_d;

  logic [StageW-1:0]       sub_idx;
  logic signed [RemW-1:0]  wt, sw, thr, rem_minus_w;
  logic                    in_empty;

  assign sub_idx     = numeral_sub(stage_q);
  assign wt          = $signed({1'b0, numeral_weight(stage_q)});
  assign sw          = $signed({1'b0, numeral_weight(sub_idx)});
  assign thr         = wt - (sw <<< 1);
  assign rem_minus_w = rem_q - wt;

  assign in_empty = value_i[ValueW-1] || (value_i == '0);

  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign stat_o.in_empty    = in_empty;
  assign stat_o.in_big      = !in_empty && ($signed(value_i) > $signed(ValueW'(MaxValue)));
  assign stat_o.can_greedy  = rem_q >= wt;
  assign stat_o.can_sub     = (stage_q != '0) && (rem_q >= thr);
  assign stat_o.greedy_zero = rem_minus_w == '0;
  assign stat_o.rem_neg     = rem_q[RemW-1];
  assign stat_o.rem_zero    = rem_q == '0;

  always_comb begin
    rem_d       = rem_q;
    stage_d     = stage_q;
    out_valid_d = out_valid_q && !out_ready_i;
    letter_d    = letter_q;
    empty_d     = empty_q;
    big_d       = big_q;
    last_d      = last_q;
    case (cmd_i.op)
      OP_LOAD: begin
        rem_d   = $signed({1'b0, value_i[WeightW-1:0]});
        stage_d = StageW'(NumStages - 1);
      end
      OP_SPECIAL: begin
        out_valid_d = 1'b1;
        letter_d    = '0;
        empty_d     = stat_o.in_empty;
        big_d       = stat_o.in_big;
        last_d      = 1'b1;
      end
      OP_GREEDY: begin
        rem_d       = rem_minus_w;
        out_valid_d = 1'b1;
        letter_d    = numeral_letter(stage_q);
        empty_d     = 1'b0;
        big_d       = 1'b0;
        last_d      = cmd_i.last;
      end
      OP_SKIP: begin
        stage_d = stage_q - 1'b1;
      end
      OP_SUB_FIRST: begin
        // Take the numeral once more and repay the first subtractor at once.
        rem_d       = rem_minus_w + sw;
        out_valid_d = 1'b1;
        letter_d    = numeral_letter(sub_idx);
        empty_d     = 1'b0;
        big_d       = 1'b0;
        last_d      = cmd_i.last;
      end
      OP_SUB_NEXT: begin
        rem_d       = rem_q + sw;
        out_valid_d = 1'b1;
        letter_d    = numeral_letter(sub_idx);
        empty_d     = 1'b0;
        big_d       = 1'b0;
        last_d      = cmd_i.last;
      end
      OP_SUB_CLOSE: begin
        stage_d     = stage_q - 1'b1;
        out_valid_d = 1'b1;
        letter_d    = numeral_letter(stage_q);
        empty_d     = 1'b0;
        big_d       = 1'b0;
        last_d      = cmd_i.last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      stage_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      stage_q     <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    letter_q <= letter_d;
    empty_q  <= empty_d;
    big_q    <= big_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign letter_o    = letter_q;
  assign empty_res_o = empty_q;
  assign too_large_o = big_q;
  assign last_o      = last_q;

endmodule

### rtl/rne_ctrl.sv
module rne_ctrl import rne_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rne_stat_t stat_i,
  output rne_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SUB
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              cnt_full;

  assign cnt_full   = cnt_q == CountW'(MaxResults - 1);
  assign in_ready_o = (state_q == ST_IDLE) && stat_i.out_free;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_IDLE;
    cmd_o.last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (stat_i.in_empty || stat_i.in_big) begin
            cmd_o.op   = OP_SPECIAL;
            cmd_o.last = 1'b1;
          end else begin
            cmd_o.op = OP_LOAD;
            cnt_d    = '0;
            state_d  = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (stat_i.can_greedy) begin
          if (stat_i.out_free) begin
            cmd_o.op   = OP_GREEDY;
            cmd_o.last = stat_i.greedy_zero || cnt_full;
            cnt_d      = cnt_q + 1'b1;
            if (cmd_o.last) begin
              state_d = ST_IDLE;
            end
          end
        end else if (stat_i.can_sub) begin
          if (stat_i.out_free) begin
            cmd_o.op   = OP_SUB_FIRST;
            cmd_o.last = cnt_full;
            cnt_d      = cnt_q + 1'b1;
            state_d    = cnt_full ? ST_IDLE : ST_SUB;
          end
        end else begin
          cmd_o.op = OP_SKIP;
        end
      end
      ST_SUB: begin
        if (stat_i.out_free) begin
          cnt_d = cnt_q + 1'b1;
          if (stat_i.rem_neg) begin
            cmd_o.op   = OP_SUB_NEXT;
            cmd_o.last = cnt_full;
          end else begin
            // The numeral closes the group; the run ends if nothing is left.
            cmd_o.op   = OP_SUB_CLOSE;
            cmd_o.last = cnt_full || stat_i.rem_zero;
            state_d    = ST_WALK;
          end
          if (cmd_o.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### rtl/integer_to_roman_numeral_encoder_core.sv
// Channel | Signals                        | Direction | Beat
// in      | in_valid_i, in_ready_o         | input     | value_i
// out     | out_valid_o, out_ready_i       | output    | letter_o, empty_res_o,
//         |                                |           | too_large_o, last_o
//
// A value is loaded, then the walk emits its letters one by one and steps down through the
// smaller numerals; a step that does not close a subtractor group (at most six) emits no
// letter. The letter walk is a single shared subtract-and-compare unit stepped by the
// controller. Zero, negative and too-large values give one flagged beat, offered in the
// cycle after the accept, with no walk.
// rst_ni clears the controller and the output valid; a stalled output beat holds the letter steps, not the steps down.
module integer_to_roman_numeral_encoder_core import rne_pkg::*; #(
  parameter int unsigned MaxValue = DefMaxValue
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ValueW-1:0]  value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LetterW-1:0] letter_o,
  output logic               empty_res_o,
  output logic               too_large_o,
  output logic               last_o
);

  rne_cmd_t  cmd;
  rne_stat_t stat;

  rne_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rne_datapath #(
    .MaxValue (MaxValue)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .letter_o    (letter_o),
    .empty_res_o (empty_res_o),
    .too_large_o (too_large_o),
    .last_o      (last_o)
  );

endmodule

### rtl/rne_checker.sv
`include "integer_to_roman_numeral_encoder_core_macros.svh"

module rne_checker import rne_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [LetterW-1:0] letter_o,
  input logic               empty_res_o,
  input logic               too_large_o,
  input logic               last_o
);

  // A beat that is offered and not taken must still be offered next cycle.
  `RNE_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> out_valid_o, "output beat dropped")

  `RNE_ASSERT(a_in_hold, (in_valid_i && !in_ready_o) |=> in_valid_i, "input beat withdrawn")

  `RNE_ASSERT_IMP(a_flag_beat_alone,
    out_valid_o && (empty_res_o || too_large_o),
    last_o && (letter_o == '0) && !(empty_res_o && too_large_o),
    "flagged beat malformed")

  `RNE_ASSERT_IMP(a_letter_nonzero,
    out_valid_o && !empty_res_o && !too_large_o,
    letter_o != '0,
    "letter beat without a letter")

  // No new value is taken while the current run still has letters to come.
  `RNE_ASSERT_IMP(a_no_accept_mid_run, out_valid_o && !last_o, !in_ready_o, "input taken during a run")

endmodule

bind integer_to_roman_numeral_encoder_core rne_checker u_rne_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .letter_o    (letter_o),
  .empty_res_o (empty_res_o),
  .too_large_o (too_large_o),
  .last_o      (last_o)
);
